>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; every macro expects clk in scope, and ASSERT_CLK also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lrog_pkg.sv
// Package for the longest-run-of-ones grid block: widths, types and run arithmetic.
// No dependencies.
`timescale 1ns / 1ps

package lrog_pkg;

    localparam int RUN_W  = 11;
    localparam int SIDE_W = 11;

    typedef logic [RUN_W-1:0]  run_t;
    typedef logic [SIDE_W-1:0] side_t;

    localparam run_t RUN_MAX = {RUN_W{1'b1}};

    // Saturating increment of a run counter
    function automatic run_t run_bump(input run_t v);
        run_t r;
        r = (v == RUN_MAX) ? v : v + run_t'(1);
        return r;
    endfunction

endpackage

>>> hw/rtl/lrog_if.sv
// Valid/ready channel interfaces for cells, results and the side register.
// Depends on lrog_pkg.
`timescale 1ns / 1ps

interface lrog_cell_if;
    logic valid;
    logic ready;
    logic cell_is_one;

    modport source (output valid, output cell_is_one, input ready);
    modport sink   (input valid, input cell_is_one, output ready);
endinterface

interface lrog_run_if import lrog_pkg::*;;
    logic valid;
    logic ready;
    run_t longest_run;

    modport source (output valid, output longest_run, input ready);
    modport sink   (input valid, input longest_run, output ready);
endinterface

interface lrog_side_if import lrog_pkg::*;;
    logic  valid;
    logic  ready;
    side_t side;

    modport source (output valid, output side, input ready);
    modport sink   (input valid, input side, output ready);
endinterface

>>> hw/rtl/longest_run_of_ones_grid.sv
// Top level: longest straight run of ones (rows, columns, down-right diagonals) in a grid.
// Depends on lrog_pkg, lrog_if and lrog_run_ram.
//
//  channel  dir  word          handshake
//  cfg      in   side          valid/ready, ready always high
//  cells    in   cell_is_one   valid/ready, raster order
//  result   out  longest_run   valid/ready, one word per grid
//
// One cell per cycle sustained while the result is not stalled; the counter RAM read is
// issued on acceptance and the update stage writes the new runs back from the s1
// registers, and the result register loads when the last cell leaves that stage.
// rst_n clears all control state; the RAM needs no clearing.
// A stalled result only holds the input back when the following grid's last cell
// reaches the update stage.
`timescale 1ns / 1ps

module longest_run_of_ones_grid
    import lrog_pkg::*;
#(
    parameter int MAX_SIDE = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    lrog_side_if.sink   cfg,
    lrog_cell_if.sink   cells,
    lrog_run_if.source  result
);

    localparam int IDX_W = $clog2(MAX_SIDE);
    localparam int CMP_W = (IDX_W + 1 > SIDE_W) ? IDX_W + 1 : SIDE_W;

    side_t              side_reg;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_one_reg;
    logic               s1_first_row_reg;
    logic               s1_first_col_reg;
    logic               s1_last_reg;
    logic [IDX_W-1:0]   s1_slot_reg;

    run_t               row_run_reg, row_run_next;
    run_t               hold_reg, hold_next;
    run_t               best_reg, best_next;
    logic               out_valid_reg, out_valid_next;
    run_t               out_run_reg, out_run_next;

    logic [CMP_W-1:0]   side_ext, side_lim, n_eff, col_inc, row_inc;
    logic               row_end, grid_end, accept, s1_go, in_ready;
    logic [2*RUN_W-1:0] rd_data;
    run_t               old_col, old_diag, pred_row, pred_col, pred_diag;
    run_t               nr, nc, nd, best_a, best_b, best_new;

    // side register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= side_t'(1);
        end
        else if (cfg.valid)
        begin
            side_reg <= cfg.side;
        end
    end

    // effective side: zero reads as one, large values clip to MAX_SIDE
    always_comb
    begin
        side_ext = CMP_W'(side_reg);
        side_lim = CMP_W'(MAX_SIDE);
        if (side_ext == '0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (side_ext > side_lim)
        begin
            n_eff = side_lim;
        end
        else
        begin
            n_eff = side_ext;
        end
    end

    assign col_inc  = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc  = CMP_W'(row_reg) + CMP_W'(1);
    assign row_end  = (col_inc >= n_eff);
    assign grid_end = row_end && (row_inc >= n_eff);

    assign s1_go       = s1_valid_reg && !(s1_last_reg && out_valid_reg && !result.ready);
    assign in_ready    = !s1_valid_reg || s1_go;
    assign cells.ready = in_ready;
    assign accept      = cells.valid && in_ready;

    // raster position
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = grid_end ? '0 : IDX_W'(row_inc);
            end
            else
            begin
                col_next = IDX_W'(col_inc);
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_one_reg       <= cells.cell_is_one;
            s1_first_row_reg <= (row_reg == '0);
            s1_first_col_reg <= (col_reg == '0);
            s1_last_reg      <= grid_end;
            s1_slot_reg      <= col_reg;
        end
    end

    lrog_run_ram #(
        .DEPTH   (MAX_SIDE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_slot_reg),
        .wr_data ({nc, nd}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    // update stage
    assign old_col  = rd_data[2*RUN_W-1:RUN_W];
    assign old_diag = rd_data[RUN_W-1:0];

    always_comb
    begin
        pred_row  = s1_first_col_reg ? '0 : row_run_reg;
        pred_col  = s1_first_row_reg ? '0 : old_col;
        pred_diag = (s1_first_row_reg || s1_first_col_reg) ? '0 : hold_reg;
        nr        = s1_one_reg ? run_bump(pred_row)  : '0;
        nc        = s1_one_reg ? run_bump(pred_col)  : '0;
        nd        = s1_one_reg ? run_bump(pred_diag) : '0;
        best_a    = (nr > best_reg) ? nr : best_reg;
        best_b    = (nc > best_a) ? nc : best_a;
        best_new  = (nd > best_b) ? nd : best_b;
    end

    always_comb
    begin
        row_run_next   = row_run_reg;
        hold_next      = hold_reg;
        best_next      = best_reg;
        out_run_next   = out_run_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (s1_go)
        begin
            if (s1_last_reg)
            begin
                row_run_next   = '0;
                hold_next      = '0;
                best_next      = '0;
                out_run_next   = best_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                row_run_next = nr;
                hold_next    = old_diag;
                best_next    = best_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_run_reg   <= '0;
            hold_reg      <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_run_reg   <= row_run_next;
            hold_reg      <= hold_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_run_reg <= out_run_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.longest_run = out_run_reg;

endmodule

>>> hw/rtl/lrog_run_ram.sv
// Counter memory holding the column and diagonal runs of the previous row.
// One write port, one registered read port with write-to-read bypass; uses lrog_pkg.
`timescale 1ns / 1ps

module lrog_run_ram
    import lrog_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [2*RUN_W-1:0]         wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [2*RUN_W-1:0]         rd_data
);

    logic [2*RUN_W-1:0] mem [DEPTH];
    logic [2*RUN_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // same-entry write and read in one cycle: new word wins
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/lrog_checker.sv
// Port-level checks for longest_run_of_ones_grid, bound to the top level.
// Depends on lrog_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrog_checker
    import lrog_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input run_t out_run,
    input logic cfg_ready
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    `ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !out_valid, "result valid during reset")
    `ASSERT_CLK(a_cfg_always_ready, cfg_ready, "side register not ready")
    `ASSERT_CLK(a_result_follows_cell, $rose(out_valid) |-> $past(in_acc, 2), "stray result")
    `ASSERT_CLK(a_result_held, out_stall |=> out_valid && $stable(out_run), "word changed")

endmodule

bind longest_run_of_ones_grid lrog_checker u_lrog_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cells.valid),
    .in_ready  (cells.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_run   (result.longest_run),
    .cfg_ready (cfg.ready)
);

>>> sim/longest_run_checker.sv
// Checker for the longest-run-of-ones grid block: watches the side, cell and result
// channels, predicts each grid's longest run and compares it. Depends on lrog_pkg, lrog_if.
`timescale 1ns / 1ps

module longest_run_checker
    import lrog_pkg::*;
#(
    parameter int MAX_SIDE = 1024
)
(
    input  logic  clk,
    input  logic  rst_n,
    lrog_side_if  cfg,
    lrog_cell_if  cells,
    lrog_run_if   result,
    output int    pending,
    output int    errors
);

    side_t side_q;
    int    row_q;
    int    col_q;
    run_t  row_run_q;
    run_t  hold_q;
    run_t  best_q;
    run_t  col_runs  [MAX_SIDE];
    run_t  diag_runs [MAX_SIDE];
    run_t  expected_runs [$];

    function automatic run_t sat_inc(input run_t v);
        return (v == RUN_MAX) ? v : v + run_t'(1);
    endfunction

    task automatic flag_error(input string what, input run_t got, input run_t want);
        $display("ERROR %0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic fold_cell(input logic one);
        int   n;
        run_t old_diag;
        run_t pr;
        run_t pc;
        run_t pd;
        run_t nr;
        run_t nc;
        run_t nd;
        n = (side_q == '0) ? 1 : (side_q > MAX_SIDE) ? MAX_SIDE : int'(side_q);
        old_diag = diag_runs[col_q];
        pr = (col_q == 0) ? '0 : row_run_q;
        pc = (row_q == 0) ? '0 : col_runs[col_q];
        pd = (row_q == 0 || col_q == 0) ? '0 : hold_q;
        nr = one ? sat_inc(pr) : '0;
        nc = one ? sat_inc(pc) : '0;
        nd = one ? sat_inc(pd) : '0;
        row_run_q        = nr;
        col_runs[col_q]  = nc;
        diag_runs[col_q] = nd;
        hold_q           = old_diag;
        if (nr > best_q)
            best_q = nr;
        if (nc > best_q)
            best_q = nc;
        if (nd > best_q)
            best_q = nd;
        if (col_q + 1 >= n)
        begin
            col_q = 0;
            if (row_q + 1 >= n)
            begin
                expected_runs.push_back(best_q);
                row_q     = 0;
                row_run_q = '0;
                hold_q    = '0;
                best_q    = '0;
            end
            else
            begin
                row_q++;
            end
        end
        else
        begin
            col_q++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_q    = side_t'(1);
            row_q     = 0;
            col_q     = 0;
            row_run_q = '0;
            hold_q    = '0;
            best_q    = '0;
            for (int i = 0; i < MAX_SIDE; i++)
            begin
                col_runs[i]  = '0;
                diag_runs[i] = '0;
            end
            expected_runs.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_runs.size() == 0)
                    flag_error("longest_run word with nothing outstanding", result.longest_run,
                               '0);
                else if (result.longest_run !== expected_runs[0])
                    flag_error("longest_run", result.longest_run, expected_runs.pop_front());
                else
                    void'(expected_runs.pop_front());
            end
            if (cells.valid && cells.ready)
                fold_cell(cells.cell_is_one);
            if (cfg.valid && cfg.ready)
                side_q = cfg.side;
            pending <= expected_runs.size();
        end
    end

endmodule

>>> sim/longest_run_of_ones_grid_tb.sv
// Top of the longest-run-of-ones grid testbench: clock, reset, cell and side stimulus,
// result back-pressure and verdict. Depends on lrog_pkg, lrog_if, longest_run_checker.
`timescale 1ns / 1ps

module longest_run_of_ones_grid_tb
    import lrog_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_COUNT  = 1250;
    localparam int HOLD_OFF    = 4;

    logic clk;
    logic rst_n;

    int gap_pct     = 14;
    int stall_pct   = 76;
    int sent_items  = 0;
    int cycle_count = 0;
    int pending;
    int errors;

    int eff_side;
    int seg_len;
    int density;
    int pick;
    side_t new_side;

    lrog_side_if cfg_ch ();
    lrog_cell_if cell_ch ();
    lrog_run_if  run_ch ();

    longest_run_of_ones_grid dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .cells  (cell_ch),
        .result (run_ch)
    );

    longest_run_checker u_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .cells   (cell_ch),
        .result  (run_ch),
        .pending (pending),
        .errors  (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        run_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_cell(input logic one);
        if (sent_items < ITEM_COUNT / 3)
        begin
            gap_pct   = 14;
            stall_pct = 76;
        end
        else if (sent_items < 2 * ITEM_COUNT / 3)
        begin
            gap_pct   = 76;
            stall_pct = 14;
        end
        else
        begin
            gap_pct   = 0;
            stall_pct = 0;
        end
        while ($urandom_range(0, 99) < gap_pct)
        begin
            cell_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cell_ch.valid       <= 1'b1;
        cell_ch.cell_is_one <= one;
        do
            @(posedge clk);
        while (!cell_ch.ready);
        sent_items++;
    endtask

    // let the block drain fully before touching the side register
    task automatic drain;
        cell_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_side(input side_t v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.side  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.side         <= '0;
        cell_ch.valid       <= 1'b0;
        cell_ch.cell_is_one <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // side of one straight out of reset
        send_cell(1'b0);
        send_cell(1'b1);
        // side zero behaves as one
        write_side(side_t'(0));
        send_cell(1'b1);
        send_cell(1'b0);
        // 2x2: full, main diagonal, anti-diagonal only
        write_side(side_t'(2));
        repeat (4) send_cell(1'b1);
        send_cell(1'b1); send_cell(1'b0); send_cell(1'b0); send_cell(1'b1);
        send_cell(1'b0); send_cell(1'b1); send_cell(1'b1); send_cell(1'b0);
        // side shrinks part way through a grid
        write_side(side_t'(3));
        repeat (4) send_cell(1'b1);
        write_side(side_t'(2));
        send_cell(1'b1);
        // maximum side, cut short
        write_side(side_t'(1024));
        repeat (3) send_cell(1'b1);
        write_side(side_t'(1));
        send_cell(1'b0);

        // oversized side saturates; one full-width row of ones
        write_side(side_t'(2047));
        repeat (1024) send_cell(1'b1);
        send_cell(1'b1); send_cell(1'b0); send_cell(1'b1);
        write_side(side_t'(1));
        send_cell(1'b0);

        eff_side = 1;
        while (sent_items < ITEM_COUNT)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                case ($urandom_range(0, 3))
                    0:       new_side = side_t'(0);
                    1:       new_side = side_t'(1024);
                    2:       new_side = side_t'(1025);
                    default: new_side = side_t'(2047);
                endcase
                eff_side = (new_side == '0) ? 1 : 1024;
                write_side(new_side);
            end
            else if (pick < 40)
            begin
                if ($urandom_range(0, 9) == 0)
                    new_side = side_t'($urandom_range(7, 16));
                else
                    new_side = side_t'($urandom_range(1, 6));
                eff_side = int'(new_side);
                write_side(new_side);
            end
            seg_len = (eff_side > 16) ? 20 : eff_side * eff_side;
            case ($urandom_range(0, 3))
                0:       density = 15;
                1:       density = 50;
                2:       density = 85;
                default: density = 100;
            endcase
            repeat (seg_len)
            begin
                send_cell($urandom_range(0, 99) < density);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
